>>> sv/box_placement_collision_check_macros.svh
// Assertion macros shared by the box placement collision checker RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef BOX_PLACEMENT_COLLISION_CHECK_MACROS_SVH
`define BOX_PLACEMENT_COLLISION_CHECK_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BPCC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bpcc assertion failed");

// Next-cycle implication, disabled during reset.
`define BPCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bpcc assertion failed");

`endif

>>> sv/bpcc_pkg.sv
// Types and constants of the box placement collision checker.
// Depends on nothing; used by box_placement_collision_check and bpcc_box_ram.
package bpcc_pkg;

  localparam int unsigned COORD_BITS = 16;

  localparam logic [1:0] FUNC_QUERY = 2'd0;
  localparam logic [1:0] FUNC_PLACE = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_OUTSIDE = 2'd1;
  localparam logic [1:0] STATUS_OVERLAP = 2'd2;
  localparam logic [1:0] STATUS_FULL    = 2'd3;

  localparam logic [1:0] CFG_VAN_LENGTH = 2'd0;
  localparam logic [1:0] CFG_VAN_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_VAN_HEIGHT = 2'd2;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic [1:0] func;
    coord_t     pos_x;
    coord_t     pos_y;
    coord_t     pos_z;
    coord_t     box_length;
    coord_t     box_width;
    coord_t     box_height;
    logic [7:0] item_tag;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] slot;
    logic [6:0] stored_count;
    logic [7:0] tag_echo;
  } rsp_t;

  typedef struct packed {
    coord_t pos_x;
    coord_t pos_y;
    coord_t pos_z;
    coord_t box_length;
    coord_t box_width;
    coord_t box_height;
  } box_t;

endpackage

>>> sv/box_placement_collision_check.sv
// Top level of the box placement collision checker.
// Depends on bpcc_pkg, bpcc_box_ram and box_placement_collision_check_macros.svh.
//
// The block holds up to MAX_BOXES placed boxes in a single-port-read table memory
// and answers one request at a time with exactly one result. A query or place that
// finds no overlap scans every stored box; the scan reads one table entry per cycle.
// The scan stops on the first overlap. A clear, or a box outside the container,
// skips the scan. The next request is accepted as soon as the sequencer is idle,
// even while the previous result still waits in the output register. Container
// registers may only be written while idle.
`include "box_placement_collision_check_macros.svh"

module box_placement_collision_check #(
  parameter int unsigned MAX_BOXES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  bpcc_pkg::req_t     req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output bpcc_pkg::rsp_t     rsp,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  bpcc_pkg::coord_t   cfg_data
);

  localparam int unsigned AW    = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_BOXES + 1);
  localparam int unsigned CW    = bpcc_pkg::COORD_BITS;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CHECK  = 5'b00010,
    S_SCAN   = 5'b00100,
    S_DECIDE = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t             state;
  bpcc_pkg::req_t     cur;
  bpcc_pkg::coord_t   van_length;
  bpcc_pkg::coord_t   van_width;
  bpcc_pkg::coord_t   van_height;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   rd_idx;
  logic [1:0]         res_status;
  logic [CNT_W-1:0]   res_slot;

  logic               ram_we;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  bpcc_pkg::box_t     ram_wdata;
  bpcc_pkg::box_t     ram_rdata;

  logic               outside;
  logic               overlap;
  logic [CW:0]        a_end_x, a_end_y, a_end_z;
  logic [CW:0]        b_end_x, b_end_y, b_end_z;
  logic [CNT_W+6:0]   count_ext;
  logic [CNT_W+5:0]   slot_ext;
  logic               out_free;

  bpcc_box_ram #(
    .DEPTH (MAX_BOXES),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign a_end_x = {1'b0, cur.pos_x} + {1'b0, cur.box_length};
  assign a_end_y = {1'b0, cur.pos_y} + {1'b0, cur.box_width};
  assign a_end_z = {1'b0, cur.pos_z} + {1'b0, cur.box_height};
  assign b_end_x = {1'b0, ram_rdata.pos_x} + {1'b0, ram_rdata.box_length};
  assign b_end_y = {1'b0, ram_rdata.pos_y} + {1'b0, ram_rdata.box_width};
  assign b_end_z = {1'b0, ram_rdata.pos_z} + {1'b0, ram_rdata.box_height};

  assign outside = (a_end_x > {1'b0, van_length}) || (a_end_y > {1'b0, van_width}) ||
                   (a_end_z > {1'b0, van_height});

  assign overlap = ({1'b0, cur.pos_x} < b_end_x) && ({1'b0, ram_rdata.pos_x} < a_end_x) &&
                   ({1'b0, cur.pos_y} < b_end_y) && ({1'b0, ram_rdata.pos_y} < a_end_y) &&
                   ({1'b0, cur.pos_z} < b_end_z) && ({1'b0, ram_rdata.pos_z} < a_end_z);

  assign ram_wdata = '{pos_x: cur.pos_x, pos_y: cur.pos_y, pos_z: cur.pos_z,
                       box_length: cur.box_length, box_width: cur.box_width,
                       box_height: cur.box_height};

  assign ram_we = (state == S_DECIDE) && (cur.func == bpcc_pkg::FUNC_PLACE) &&
                  (count < CNT_W'(MAX_BOXES));

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = rd_idx[AW-1:0];
    if (state == S_CHECK) begin
      ram_re    = !(cur.func == bpcc_pkg::FUNC_CLEAR) && !outside && (count != '0);
      ram_raddr = '0;
    end else if (state == S_SCAN) begin
      ram_re    = !overlap && (rd_idx != count);
    end
  end

  assign req_stall = (state != S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign count_ext = {7'd0, count};
  assign slot_ext  = {6'd0, res_slot};

  always_ff @(posedge clk) begin
    if (rst) begin
      van_length <= '1;
      van_width  <= '1;
      van_height <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        bpcc_pkg::CFG_VAN_LENGTH: van_length <= cfg_data;
        bpcc_pkg::CFG_VAN_WIDTH:  van_width  <= cfg_data;
        bpcc_pkg::CFG_VAN_HEIGHT: van_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if ((state == S_FINISH) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur   <= req;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          res_slot <= '0;
          rd_idx   <= CNT_W'(1);
          if (cur.func == bpcc_pkg::FUNC_CLEAR) begin
            count      <= '0;
            res_status <= bpcc_pkg::STATUS_DONE;
            state      <= S_FINISH;
          end else if (outside) begin
            res_status <= bpcc_pkg::STATUS_OUTSIDE;
            state      <= S_FINISH;
          end else if (count == '0) begin
            state <= S_DECIDE;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (overlap) begin
            res_status <= bpcc_pkg::STATUS_OVERLAP;
            state      <= S_FINISH;
          end else if (rd_idx == count) begin
            state <= S_DECIDE;
          end else begin
            rd_idx <= rd_idx + CNT_W'(1);
          end
        end
        S_DECIDE: begin
          if (cur.func == bpcc_pkg::FUNC_PLACE) begin
            if (count < CNT_W'(MAX_BOXES)) begin
              res_status <= bpcc_pkg::STATUS_DONE;
              res_slot   <= count;
              count      <= count + CNT_W'(1);
            end else begin
              res_status <= bpcc_pkg::STATUS_FULL;
            end
          end else begin
            res_status <= bpcc_pkg::STATUS_DONE;
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            rsp.status       <= res_status;
            rsp.slot         <= slot_ext[5:0];
            rsp.stored_count <= count_ext[6:0];
            rsp.tag_echo     <= cur.item_tag;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BPCC_ASSERT_NOW(a_count_bounded, clk, rst, 1'b1, count <= CNT_W'(MAX_BOXES))
  `BPCC_ASSERT_NOW(a_write_has_room, clk, rst, ram_we, count < CNT_W'(MAX_BOXES))
  `BPCC_ASSERT_NOW(a_scan_in_table, clk, rst, state == S_SCAN, rd_idx <= count && rd_idx != '0)
  `BPCC_ASSERT_NEXT(a_accept_starts, clk, rst, req_valid && !req_stall, state == S_CHECK)
  `BPCC_ASSERT_NEXT(a_finish_loads, clk, rst, state == S_FINISH && out_free, rsp_valid)

endmodule

>>> sv/bpcc_box_ram.sv
// Box table memory: one write port, one read port, registered read data.
// Depends on bpcc_pkg for the box entry type.
module bpcc_box_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  bpcc_pkg::box_t     wdata,
  input  logic               re,
  input  logic [AW-1:0]      raddr,
  output bpcc_pkg::box_t     rdata
);

  bpcc_pkg::box_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
